// ----- rtl/hsde_pkg.sv -----
package hsde_pkg;

	// Fixed-point formats of the ports
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 8;
	localparam int CFG_IDX_W = 3;

	// Angle constants in 1/128 degree
	localparam int FULL_TURN    = 46080;
	localparam int HALF_TURN    = 23040;
	localparam int QUARTER_TURN = 11520;
	localparam int DIP_LIMIT    = 11507;

	// CORDIC: gain-compensated start value in Q1.29, arctangents in 1/32768 degree
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_GAIN  = 326016437;
	localparam logic signed [24:0] ATAN_STEPS [CORDIC_STEPS] = '{
		25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
		25'sd117189,  25'sd58652,  25'sd29333,  25'sd14667,
		25'sd7334,    25'sd3667,   25'sd1833,   25'sd917,
		25'sd458,     25'sd229,    25'sd115,    25'sd57
	};

	// exp(-t): ln2 in Q16, its reciprocal scaled by 2^37 (rounded up)
	localparam int LN2_Q16   = 45426;
	localparam int LN2_RECIP = 3025558;
	localparam int EXP_TERMS = 10;
	// floor(2^34 / i) + 1 for the series divisors 1..10
	localparam logic [34:0] EXP_RECIP [EXP_TERMS] = '{
		35'd17179869185, 35'd8589934593, 35'd5726623062, 35'd4294967297,
		35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483649,
		35'd1908874354,  35'd1717986919
	};

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_REF_DEPTH = 3'd1,
		REG_CENTER_X  = 3'd2,
		REG_CENTER_Y  = 3'd3,
		REG_AZIMUTH   = 3'd4,
		REG_DIP_ANGLE = 3'd5,
		REG_AMPLITUDE = 3'd6,
		REG_SPREAD    = 3'd7
	} cfg_reg_t;

	// Request and result payloads
	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
	} hsde_item_t;

	typedef struct packed {
		logic signed [31:0] depth;
		logic               saturated;
	} hsde_result_t;

endpackage

// ----- rtl/horizon_surface_depth_evaluator.sv -----
// Throughput: one request per cycle while busy is low; busy is low whenever the setup unit is idle.
// Setup: after reset and after every register write, the setup unit derives the plane
// constants with a shared CORDIC and the spread constants by scaling, with busy high.
// The receiver cannot stall; done marks each result for one cycle.
// Async active-low reset initialises the configuration registers, valid chain and setup state.
module horizon_surface_depth_evaluator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  hsde_pkg::hsde_item_t            item,
	output logic                            done,
	output hsde_pkg::hsde_result_t          result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hsde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import hsde_pkg::*;

	localparam int LAT = 50;
	localparam int GD  = 7;   // spread divider stages, 3 bits each
	localparam int PD  = 11;  // tangent divider stages, 3 bits each
	localparam int PDL = 29;  // plane term delay to meet the Gaussian path

	localparam logic signed [30:0] CE_VERT = 31'sd536870912;

	// Configuration registers
	logic               mode_q;
	logic signed [31:0] ref_q, cx_q, cy_q, amp_q;
	logic [15:0]        az_q;
	logic [13:0]        dip_q;
	logic [30:0]        spread_q;
	logic               cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			ref_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			az_q     <= '0;
			dip_q    <= '0;
			amp_q    <= '0;
			spread_q <= 31'(1 << FRAC_BITS);
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:      mode_q   <= cfg_data[0];
				REG_REF_DEPTH: ref_q    <= cfg_data;
				REG_CENTER_X:  cx_q     <= cfg_data;
				REG_CENTER_Y:  cy_q     <= cfg_data;
				REG_AZIMUTH:   az_q     <= cfg_data[15:0];
				REG_DIP_ANGLE: dip_q    <= cfg_data[13:0];
				REG_AMPLITUDE: amp_q    <= cfg_data;
				REG_SPREAD:    spread_q <= cfg_data[30:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Setup unit: one CORDIC shared by azimuth and dip, plus spread scaling
	// ------------------------------------------------------------------
	typedef enum logic [1:0] {ST_SETUP, ST_AZ, ST_DIP, ST_IDLE} st_t;

	st_t                st_q;
	logic signed [31:0] cor_x_q, cor_y_q;
	logic signed [24:0] cor_z_q;
	logic [3:0]         step_q;
	logic               vert_q, flip_q;
	logic [13:0]        dcl_q;
	logic [3:0]         k_q;
	logic [19:0]        sp_q;
	logic [33:0]        s8_q;
	logic signed [30:0] ce_q, se_q;
	logic [29:0]        sd_q, cd_q;
	logic [40:0]        den_q;

	logic signed [31:0] cor_sx, cor_sy, cx_n, cy_n;
	logic signed [24:0] cor_at, cz_n;
	logic [15:0]        az_r;
	logic signed [17:0] b0, b1;
	logic               b_neg, vert_w, flip_w;
	logic signed [24:0] z0;
	logic [13:0]        dcl_w;
	logic [30:0]        s_nz;
	logic [3:0]         kk;
	logic [39:0]        sp_sq;

	assign busy = (st_q != ST_IDLE);

	// CORDIC rotation step
	always_comb begin
		cor_sx = cor_y_q >>> step_q;
		cor_sy = cor_x_q >>> step_q;
		cor_at = ATAN_STEPS[step_q];
		if (!cor_z_q[24]) begin
			cx_n = cor_x_q - cor_sx;
			cy_n = cor_y_q + cor_sy;
			cz_n = cor_z_q - cor_at;
		end else begin
			cx_n = cor_x_q + cor_sx;
			cy_n = cor_y_q - cor_sy;
			cz_n = cor_z_q + cor_at;
		end
	end

	// Azimuth folding into +-90 degrees, dip clamp, spread prescale
	always_comb begin
		az_r   = (az_q >= 16'(FULL_TURN)) ? az_q - 16'(FULL_TURN) : az_q;
		vert_w = (az_r == '0) || (az_r == 16'(HALF_TURN));
		b0     = (az_r > 16'(HALF_TURN)) ? $signed({2'b00, az_r}) - 18'sd46080
		                                 : $signed({2'b00, az_r});
		b_neg  = 1'b0;
		b1     = b0;
		if (b0 > 18'sd11520) begin
			b1    = b0 - 18'sd23040;
			b_neg = 1'b1;
		end else if (b0 < -18'sd11520) begin
			b1    = b0 + 18'sd23040;
			b_neg = 1'b1;
		end
		z0     = {b1[16:0], 8'b0};
		flip_w = b_neg ^ (az_r > 16'(HALF_TURN));
		dcl_w  = (dip_q > 14'(DIP_LIMIT)) ? 14'(DIP_LIMIT) : dip_q;
		s_nz   = (spread_q == '0) ? 31'd1 : spread_q;
		kk     = '0;
		for (int j = 1; j <= 11; j++) begin
			if (s_nz[19+j])
				kk = 4'(j);
		end
		sp_sq  = 40'(sp_q) * 40'(sp_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_SETUP;
			cor_x_q <= '0;
			cor_y_q <= '0;
			cor_z_q <= '0;
			step_q  <= '0;
			vert_q  <= 1'b0;
			flip_q  <= 1'b0;
			dcl_q   <= '0;
			k_q     <= '0;
			sp_q    <= '0;
			s8_q    <= '0;
			ce_q    <= '0;
			se_q    <= '0;
			sd_q    <= '0;
			cd_q    <= 30'd1;
			den_q   <= '0;
		end else if (cfg_wr) begin
			st_q <= ST_SETUP;
		end else begin
			unique case (st_q)
				ST_SETUP: begin
					vert_q  <= vert_w;
					flip_q  <= flip_w;
					dcl_q   <= dcl_w;
					k_q     <= kk;
					sp_q    <= 20'(s_nz >> kk);
					s8_q    <= {s_nz, 3'b000};
					cor_x_q <= 32'(CORDIC_GAIN);
					cor_y_q <= '0;
					cor_z_q <= z0;
					step_q  <= '0;
					st_q    <= ST_AZ;
				end
				ST_AZ: begin
					cor_x_q <= cx_n;
					cor_y_q <= cy_n;
					cor_z_q <= cz_n;
					step_q  <= step_q + 4'd1;
					if (step_q == 4'(CORDIC_STEPS - 1)) begin
						ce_q    <= vert_q ? CE_VERT : (flip_q ? 31'(-cx_n) : 31'(cx_n));
						se_q    <= vert_q ? '0 : (flip_q ? 31'(-cy_n) : 31'(cy_n));
						cor_x_q <= 32'(CORDIC_GAIN);
						cor_y_q <= '0;
						cor_z_q <= {3'b000, dcl_q, 8'b0};
						step_q  <= '0;
						st_q    <= ST_DIP;
					end
				end
				ST_DIP: begin
					cor_x_q <= cx_n;
					cor_y_q <= cy_n;
					cor_z_q <= cz_n;
					step_q  <= step_q + 4'd1;
					if (step_q == 4'(CORDIC_STEPS - 1)) begin
						sd_q  <= ((dcl_q == '0) || cy_n[31]) ? '0 : cy_n[29:0];
						cd_q  <= (cx_n < 32'sd1) ? 30'd1 : cx_n[29:0];
						den_q <= {sp_sq, 1'b0};
						st_q  <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Valid chain and output strobe
	// ------------------------------------------------------------------
	logic [LAT-1:0] vld_q;
	logic           acc_w;

	assign acc_w = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], acc_w};
	end

	assign done = vld_q[LAT-1];

	// ------------------------------------------------------------------
	// Stage 1: offsets from the center
	// ------------------------------------------------------------------
	logic signed [32:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= 33'(item.x_coord) - 33'(cx_q);
		dy_s1 <= 33'(item.y_coord) - 33'(cy_q);
	end

	// ------------------------------------------------------------------
	// Plane path
	// ------------------------------------------------------------------
	logic signed [63:0] mc_s2, ms_s2, diff_s3;
	logic [62:0]        pm_s4;
	logic               pn_s4, pn_s5, pn_s6, pn_s7;
	logic [33:0]        dm_s5;
	logic [46:0]        plo_s6, phi_s6;
	logic [63:0]        num_s7;

	always_ff @(posedge clk) begin
		mc_s2   <= ce_q * dx_s1;
		ms_s2   <= se_q * dy_s1;
		diff_s3 <= mc_s2 - ms_s2;
		pn_s4   <= diff_s3[63];
		pm_s4   <= diff_s3[63] ? 63'(-diff_s3) : 63'(diff_s3);
		// round the distance to Q26.8, half away from zero
		pn_s5   <= pn_s4;
		dm_s5   <= 34'((64'(pm_s4) + 64'(1 << 28)) >> 29);
		// |dist| * sin(dip) as two partial products
		pn_s6   <= pn_s5;
		plo_s6  <= dm_s5[16:0] * sd_q;
		phi_s6  <= dm_s5[33:17] * sd_q;
		pn_s7   <= pn_s6;
		num_s7  <= 64'(plo_s6) + {phi_s6, 17'b0} + 64'(cd_q >> 1);
	end

	// Restoring divider by cos(dip), quotient capped at 2^33
	logic [29:0] pd_rem_s [PD+1];
	logic [32:0] pd_nlo_s [PD+1];
	logic [32:0] pd_q_s   [PD+1];
	logic        pd_ovf_s [PD+1];
	logic        pd_neg_s [PD+1];

	always_ff @(posedge clk) begin
		pd_ovf_s[0] <= (num_s7 >= {1'b0, cd_q, 33'b0});
		pd_rem_s[0] <= 30'(num_s7 >> 33);
		pd_nlo_s[0] <= num_s7[32:0];
		pd_q_s[0]   <= '0;
		pd_neg_s[0] <= pn_s7;
	end

	for (genvar j = 0; j < PD; j++) begin : g_pdiv
		logic [29:0] rem;
		logic [30:0] r2;
		logic [32:0] nl, q;

		always_comb begin
			rem = pd_rem_s[j];
			nl  = pd_nlo_s[j];
			q   = pd_q_s[j];
			r2  = '0;
			for (int b = 0; b < 3; b++) begin
				r2 = {rem, nl[32]};
				nl = {nl[31:0], 1'b0};
				if (r2 >= {1'b0, cd_q}) begin
					rem = 30'(r2 - {1'b0, cd_q});
					q   = {q[31:0], 1'b1};
				end else begin
					rem = r2[29:0];
					q   = {q[31:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			pd_rem_s[j+1] <= rem;
			pd_nlo_s[j+1] <= nl;
			pd_q_s[j+1]   <= q;
			pd_ovf_s[j+1] <= pd_ovf_s[j];
			pd_neg_s[j+1] <= pd_neg_s[j];
		end
	end

	// Signed plane term, then delayed to line up with the Gaussian term
	logic [33:0]        pt_mag;
	logic signed [34:0] pt_s [PDL+1];

	assign pt_mag = pd_ovf_s[PD] ? {1'b1, 33'b0} : {1'b0, pd_q_s[PD]};

	always_ff @(posedge clk) begin
		pt_s[0] <= pd_neg_s[PD] ? -35'(pt_mag) : 35'(pt_mag);
	end

	for (genvar j = 0; j < PDL; j++) begin : g_pdly
		always_ff @(posedge clk) begin
			pt_s[j+1] <= pt_s[j];
		end
	end

	// ------------------------------------------------------------------
	// Gaussian path
	// ------------------------------------------------------------------
	logic [32:0] e_s2, f_s2;
	logic        far_s3, far_s4;
	logic [22:0] es_s3, fs_s3;
	logic [45:0] qe_s4, qf_s4;
	logic [46:0] sum_w;

	always_ff @(posedge clk) begin
		e_s2   <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
		f_s2   <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		// outside eight sigma the bump contributes nothing
		far_s3 <= ({1'b0, e_s2} >= s8_q) || ({1'b0, f_s2} >= s8_q);
		es_s3  <= 23'(e_s2 >> k_q);
		fs_s3  <= 23'(f_s2 >> k_q);
		far_s4 <= far_s3;
		qe_s4  <= es_s3 * es_s3;
		qf_s4  <= fs_s3 * fs_s3;
	end

	assign sum_w = 47'(qe_s4) + 47'(qf_s4);

	// Restoring divider by 2*sigma^2; a quotient of 32.0 or more zeroes the term
	logic [40:0] gd_rem_s [GD+1];
	logic [20:0] gd_nlo_s [GD+1];
	logic [20:0] gd_q_s   [GD+1];
	logic        gd_z_s   [GD+1];

	always_ff @(posedge clk) begin
		gd_z_s[0]   <= far_s4 || (sum_w >= {1'b0, den_q, 5'b0});
		gd_rem_s[0] <= 41'(sum_w >> 5);
		gd_nlo_s[0] <= {sum_w[4:0], 16'b0};
		gd_q_s[0]   <= '0;
	end

	for (genvar j = 0; j < GD; j++) begin : g_gdiv
		logic [40:0] rem;
		logic [41:0] r2;
		logic [20:0] nl, q;

		always_comb begin
			rem = gd_rem_s[j];
			nl  = gd_nlo_s[j];
			q   = gd_q_s[j];
			r2  = '0;
			for (int b = 0; b < 3; b++) begin
				r2 = {rem, nl[20]};
				nl = {nl[19:0], 1'b0};
				if (r2 >= {1'b0, den_q}) begin
					rem = 41'(r2 - {1'b0, den_q});
					q   = {q[19:0], 1'b1};
				end else begin
					rem = r2[40:0];
					q   = {q[19:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			gd_rem_s[j+1] <= rem;
			gd_nlo_s[j+1] <= nl;
			gd_q_s[j+1]   <= q;
			gd_z_s[j+1]   <= gd_z_s[j];
		end
	end

	// Base-2 split: t = n*ln2 + rem
	logic [42:0]        tp_s13;
	logic [20:0]        t_s13, t_s14;
	logic               gz_s13, gz_s14;
	logic [5:0]         ne_s14;
	logic [21:0]        nl_s14;
	logic signed [22:0] rm_w;
	logic [15:0]        rmf_w;
	logic [5:0]         n_w;

	always_ff @(posedge clk) begin
		tp_s13 <= 43'(gd_q_s[GD]) * 43'(LN2_RECIP);
		t_s13  <= gd_q_s[GD];
		gz_s13 <= gd_z_s[GD];
		ne_s14 <= tp_s13[42:37];
		nl_s14 <= 22'(tp_s13[42:37]) * 22'(LN2_Q16);
		t_s14  <= t_s13;
		gz_s14 <= gz_s13;
	end

	always_comb begin
		rm_w = $signed({2'b00, t_s14}) - $signed({1'b0, nl_s14});
		if (rm_w[22]) begin
			n_w   = ne_s14 - 6'd1;
			rmf_w = 16'(rm_w + 23'sd45426);
		end else begin
			n_w   = ne_s14;
			rmf_w = rm_w[15:0];
		end
	end

	// Ten-term series for exp(-r), three stages per term
	logic [30:0]        ex_term_s [EXP_TERMS+1];
	logic signed [32:0] ex_acc_s  [EXP_TERMS+1];
	logic [29:0]        ex_r_s    [EXP_TERMS+1];
	logic [5:0]         ex_n_s    [EXP_TERMS+1];
	logic               ex_z_s    [EXP_TERMS+1];

	always_ff @(posedge clk) begin
		ex_term_s[0] <= 31'(1 << 30);
		ex_acc_s[0]  <= 33'(1 << 30);
		ex_r_s[0]    <= {rmf_w, 14'b0};
		ex_n_s[0]    <= n_w;
		ex_z_s[0]    <= gz_s14;
	end

	for (genvar gi = 1; gi <= EXP_TERMS; gi++) begin : g_exp
		logic [60:0]        a_pr;
		logic signed [32:0] a_acc, b_acc;
		logic [29:0]        a_r, b_r;
		logic [5:0]         a_n, b_n;
		logic               a_z, b_z;
		logic [30:0]        b_v;
		logic [65:0]        b_pm;
		logic [30:0]        qd;

		// floor(v / i) from the reciprocal estimate, which is at most one high
		always_comb begin
			qd = b_pm[64:34];
			if ((35'(qd) * 35'(gi)) > 35'(b_v))
				qd = qd - 31'd1;
		end

		always_ff @(posedge clk) begin
			a_pr  <= 61'(ex_term_s[gi-1]) * 61'(ex_r_s[gi-1]);
			a_acc <= ex_acc_s[gi-1];
			a_r   <= ex_r_s[gi-1];
			a_n   <= ex_n_s[gi-1];
			a_z   <= ex_z_s[gi-1];

			b_v   <= a_pr[60:30];
			b_pm  <= 66'(a_pr[60:30]) * 66'(EXP_RECIP[gi-1]);
			b_acc <= a_acc;
			b_r   <= a_r;
			b_n   <= a_n;
			b_z   <= a_z;

			ex_term_s[gi] <= qd;
			ex_r_s[gi]    <= b_r;
			ex_n_s[gi]    <= b_n;
			ex_z_s[gi]    <= b_z;
		end

		if ((gi % 2) == 1) begin : g_odd
			always_ff @(posedge clk) begin
				ex_acc_s[gi] <= b_acc - $signed({2'b00, qd});
			end
		end else begin : g_even
			always_ff @(posedge clk) begin
				ex_acc_s[gi] <= b_acc + $signed({2'b00, qd});
			end
		end
	end

	// Scale by 2^-n, multiply by the amplitude, round away from zero
	logic [31:0]        acp_w;
	logic [30:0]        sh_s46;
	logic signed [63:0] gp_s47;
	logic [62:0]        gm_s48;
	logic               gn_s48;
	logic [33:0]        gr_w;
	logic signed [34:0] gt_s49;

	assign acp_w = ex_acc_s[EXP_TERMS][32] ? '0 : ex_acc_s[EXP_TERMS][31:0];
	assign gr_w  = 34'((64'(gm_s48) + 64'(1 << 29)) >> 30);

	always_ff @(posedge clk) begin
		sh_s46 <= ex_z_s[EXP_TERMS] ? '0 : 31'(acp_w >> ex_n_s[EXP_TERMS]);
		gp_s47 <= amp_q * $signed({1'b0, sh_s46});
		gn_s48 <= gp_s47[63];
		gm_s48 <= gp_s47[63] ? 63'(-gp_s47) : 63'(gp_s47);
		gt_s49 <= gn_s48 ? -35'(gr_w) : 35'(gr_w);
	end

	// ------------------------------------------------------------------
	// Output: add reference depth and saturate to 32 bits
	// ------------------------------------------------------------------
	logic signed [34:0] term_w;
	logic signed [35:0] z_w;
	hsde_result_t       result_q;

	assign term_w = mode_q ? gt_s49 : pt_s[PDL];
	assign z_w    = 36'(ref_q) + 36'(term_w);

	always_ff @(posedge clk) begin
		if (z_w > 36'sd2147483647) begin
			result_q.depth     <= 32'sh7FFFFFFF;
			result_q.saturated <= 1'b1;
		end else if (z_w < -36'sd2147483648) begin
			result_q.depth     <= 32'sh80000000;
			result_q.saturated <= 1'b1;
		end else begin
			result_q.depth     <= z_w[31:0];
			result_q.saturated <= 1'b0;
		end
	end

	assign result = result_q;

endmodule
